@@ rtl/mobd_pkg.sv @@
package mobd_pkg;

   // stream layout
   localparam logic [4:0] MARKER_BYTES = 5'd4;
   localparam logic [4:0] WORD_BYTES   = 5'd4;
   localparam logic [4:0] MAX_FIRST    = MARKER_BYTES + WORD_BYTES;
   localparam logic [4:0] COUNT_FIRST  = MAX_FIRST + WORD_BYTES;
   localparam logic [4:0] HEADER_BYTES = COUNT_FIRST + WORD_BYTES;
   localparam logic [4:0] HEADER_LAST  = HEADER_BYTES - 5'd1;
   localparam logic [3:0] BYTE_BITS    = 4'd8;

   // input word
   typedef struct packed {
      logic [7:0] stream_byte;
      logic       frame_start;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [31:0] value;
      logic               last_value;
   } rsp_type;

   // one extraction step on the current byte
   typedef struct packed {
      logic        emit;
      logic [3:0]  take;
      logic [31:0] acc;
      logic [3:0]  avail;
      logic [7:0]  bits;
   } unpack_type;

   // field width: floor(log2(r)) + 1, and 1 for r of zero or one
   function automatic logic [5:0] field_width_of(input logic [31:0] rng);
      logic [31:0] r;
      logic [4:0]  lg;
      r  = rng;
      lg = '0;
      if (r[31:16] != '0) begin
         lg[4] = 1'b1;
         r     = r >> 16;
      end
      if (r[15:8] != '0) begin
         lg[3] = 1'b1;
         r     = r >> 8;
      end
      if (r[7:4] != '0) begin
         lg[2] = 1'b1;
         r     = r >> 4;
      end
      if (r[3:2] != '0) begin
         lg[1] = 1'b1;
         r     = r >> 2;
      end
      if (r[1]) begin
         lg[0] = 1'b1;
      end
      return {1'b0, lg} + 6'd1;
   endfunction

endpackage

@@ rtl/mobd_unpack.sv @@
module mobd_unpack
   import mobd_pkg::*;
(
   input  logic [7:0]  bits,
   input  logic [3:0]  avail,
   input  logic [5:0]  width,
   input  logic [5:0]  got,
   input  logic [31:0] acc,
   output unpack_type  step
);

   logic [5:0]  need;
   logic [7:0]  chunk;

   // take the bits still missing from the field, or all bits left in the byte
   assign need = width - got;

   always_comb begin
      step.emit = (need <= {2'b00, avail});
      step.take = step.emit ? need[3:0] : avail;
      chunk     = bits >> (BYTE_BITS - step.take);
      step.acc  = (acc << step.take) | {24'h000000, chunk};
      step.avail = avail - step.take;
      step.bits = bits << step.take;
   end

endmodule

@@ rtl/min_offset_bitpacked_decoder_unit.sv @@
// An accepted byte is held in the byte register; each result word it completes is then registered.
// A header byte is consumed whole; a payload byte gives up its bits value by value, each step
// completing a value or taking the bits left over for the next field, while the result register
// is free to take a value (a one-bit field width gives eight values from one byte).
// A single extraction step works on the byte register; the next byte is taken in the step that ends this one.
// Reset: synchronous, active high; frame state returns to that of a fresh frame.
module min_offset_bitpacked_decoder_unit
   import mobd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // byte register
   logic        busy_ff, busy_in;
   logic        start_ff, start_in;
   logic [7:0]  bits_ff, bits_in;
   logic [3:0]  avail_ff, avail_in;

   // frame state
   logic [4:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] min_ff, min_in;
   logic [31:0] max_ff, max_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] range_ff, range_in;
   logic [5:0]  width_ff, width_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0]  got_ff, got_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   unpack_type  ustep;
   logic        hdr_phase;
   logic        emit;
   logic        out_free;
   logic        step;
   logic        byte_done;
   logic        accept;
   logic [4:0]  pos;

   mobd_unpack u_unpack (
      .bits  (bits_ff),
      .avail (avail_ff),
      .width (width_ff),
      .got   (got_ff),
      .acc   (acc_ff),
      .step  (ustep)
   );

   // step control
   assign hdr_phase = start_ff || (hdr_cnt_ff < HEADER_BYTES);
   assign emit      = !hdr_phase && (left_ff != '0) && ustep.emit;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = busy_ff && (!emit || out_free);
   assign byte_done = hdr_phase || (left_ff == '0) || (emit && (left_ff == 32'd1))
                      || (ustep.avail == '0);
   assign req_ready = !busy_ff || (step && byte_done);
   assign accept    = req_valid && req_ready;

   // byte register next state
   always_comb begin
      busy_in  = busy_ff;
      start_in = start_ff;
      bits_in  = bits_ff;
      avail_in = avail_ff;
      if (accept) begin
         busy_in  = 1'b1;
         start_in = req_data.frame_start;
         bits_in  = req_data.stream_byte;
         avail_in = BYTE_BITS;
      end else if (step) begin
         busy_in  = !byte_done;
         start_in = 1'b0;
         bits_in  = ustep.bits;
         avail_in = ustep.avail;
      end
   end

   // frame state next state
   always_comb begin
      hdr_cnt_in = hdr_cnt_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      left_in    = left_ff;
      range_in   = range_ff;
      width_in   = width_ff;
      acc_in     = acc_ff;
      got_in     = got_ff;
      pos        = start_ff ? '0 : hdr_cnt_ff;
      if (step) begin
         if (hdr_phase) begin
            if (start_ff) begin
               min_in   = '0;
               max_in   = '0;
               left_in  = '0;
               width_in = 6'd1;
               acc_in   = '0;
               got_in   = '0;
            end
            if (pos >= MARKER_BYTES && pos < MAX_FIRST) begin
               min_in = {min_in[23:0], bits_ff};
            end else if (pos >= MAX_FIRST && pos < COUNT_FIRST) begin
               max_in = {max_in[23:0], bits_ff};
            end else if (pos >= COUNT_FIRST) begin
               left_in = {left_in[23:0], bits_ff};
            end
            // minimum and maximum are complete once the count starts
            if (pos == COUNT_FIRST) begin
               range_in = max_ff - min_ff + 32'd1;
            end
            if (pos == HEADER_LAST) begin
               width_in = field_width_of(range_ff);
               acc_in   = '0;
               got_in   = '0;
            end
            hdr_cnt_in = pos + 5'd1;
         end else if (left_ff != '0) begin
            if (ustep.emit) begin
               left_in = left_ff - 32'd1;
               acc_in  = '0;
               got_in  = '0;
            end else begin
               acc_in = ustep.acc;
               got_in = got_ff + {2'b00, ustep.take};
            end
         end
      end
   end

   // result register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step && emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.value      = ustep.acc + min_ff;
         rsp_data_in.last_value = (left_ff == 32'd1);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and frame registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hdr_cnt_ff   <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         left_ff      <= '0;
         range_ff     <= '0;
         width_ff     <= 6'd1;
         acc_ff       <= '0;
         got_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         left_ff      <= left_in;
         range_ff     <= range_in;
         width_ff     <= width_in;
         acc_ff       <= acc_in;
         got_ff       <= got_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      bits_ff     <= bits_in;
      avail_ff    <= avail_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/mobd_checker.sv @@
module mobd_checker
   import mobd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a stalled result word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result word changed while stalled");

   // a waiting input word is held until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("input word changed while waiting");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // while reset is held, a frame-start input word is not taken together with a handed-over result word
   a_no_accept_reset: assert property (@(posedge clock)
      $past(reset) && reset |-> !(rsp_valid && req_valid && req_data.frame_start
                                  && req_ready && rsp_ready))
      else $error("traffic during reset");

endmodule

bind min_offset_bitpacked_decoder_unit mobd_checker u_mobd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
